@@ sv/ltpg_pkg.sv @@
// Shared types and constants for the line trajectory point generator.
package ltpg_pkg;

   localparam int MaxPoints = 64;
   localparam int CoordBits = 16;
   localparam int CntBits = $clog2(MaxPoints + 1);
   localparam int DBits = CoordBits + 1;
   localparam int D2Bits = 2 * DBits;
   localparam int RootBits = DBits + 1;

   typedef struct packed {
      logic signed [15:0] from_x;
      logic signed [15:0] from_y;
      logic signed [15:0] to_x;
      logic signed [15:0] to_y;
      logic [15:0]        step_len;
   } req_type;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic               last;
      logic               capped;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic sqrt_init;
      logic sqrt_step;
      logic div_init;
      logic div_step;
      logic count_fix;
      logic pt_init;
      logic pt_mul;
      logic pt_div_init;
      logic pt_div_step;
      logic pt_emit;
   } cmd_type;

   typedef struct packed {
      logic sqrt_done;
      logic div_done;
      logic pdiv_done;
      logic run_last;
   } sts_type;

endpackage

@@ sv/ltpg_datapath.sv @@
// Datapath: square root, count divider, per-point multiply and rounding divide.
module ltpg_datapath (
   input  logic              clock,
   input  ltpg_pkg::req_type req_data,
   input  ltpg_pkg::cmd_type cmd,
   output ltpg_pkg::sts_type sts,
   output ltpg_pkg::rsp_type rsp_data
);
   import ltpg_pkg::*;

   localparam int SqIter = D2Bits / 2;
   localparam int SqCntBits = $clog2(SqIter + 1);
   localparam int QBits = RootBits;
   localparam int QCntBits = $clog2(QBits + 1);
   localparam int ProdBits = DBits + CntBits;
   localparam int PCntBits = $clog2(ProdBits + 1);

   logic signed [DBits-1:0] fx_ff, fy_ff, dx_ff, dy_ff;
   logic signed [DBits-1:0] fx_in, fy_in, dx_in, dy_in;
   logic signed [DBits-1:0] tx_ext, ty_ext;
   logic [15:0]             step_ff, step_in;

   logic [D2Bits-1:0]       sq_rem_ff, sq_rem_in;
   logic [RootBits-1:0]     sq_root_ff, sq_root_in;
   logic [SqCntBits-1:0]    sq_cnt_ff, sq_cnt_in;
   logic [D2Bits-1:0]       dxsq_ff, dysq_ff;
   logic [RootBits+1:0]     sq_trial;

   logic [QBits-1:0]        q_ff, q_in;
   logic [16:0]             r_ff, r_in;
   logic [QCntBits-1:0]     q_cnt_ff, q_cnt_in;
   logic [17:0]             r_shift;

   logic [CntBits-1:0]      n_ff, n_in;
   logic                    capped_ff, capped_in;
   logic [CntBits-1:0]      k_ff, k_in;

   logic signed [ProdBits-1:0] px_ff, py_ff;
   logic [ProdBits-1:0]     mx_ff, my_ff, mx_in, my_in;
   logic                    nx_ff, ny_ff;
   logic [ProdBits-1:0]     qx_ff, qy_ff, qx_in, qy_in;
   logic [CntBits:0]        rx_ff, ry_ff, rx_in, ry_in;
   logic [PCntBits-1:0]     p_cnt_ff, p_cnt_in;
   logic [CntBits+1:0]      rxs, rys;
   logic [CntBits-1:0]      f_val;

   logic signed [DBits:0]   ox, oy;
   logic [ProdBits-1:0]     qx_r, qy_r;
   logic signed [ProdBits:0] sx, sy;

   assign tx_ext = DBits'(req_data.to_x);
   assign ty_ext = DBits'(req_data.to_y);

   always_comb begin
      fx_in = fx_ff; fy_in = fy_ff; dx_in = dx_ff; dy_in = dy_ff; step_in = step_ff;
      if (cmd.load) begin
         fx_in = DBits'(req_data.from_x);
         fy_in = DBits'(req_data.from_y);
         dx_in = tx_ext - DBits'(req_data.from_x);
         dy_in = ty_ext - DBits'(req_data.from_y);
         step_in = (req_data.step_len == 16'd0) ? 16'd1 : req_data.step_len;
      end
   end

   // Restoring square root, two radicand bits per step.
   always_comb begin
      logic [RootBits+1:0] rem_hi;
      sq_rem_in = sq_rem_ff;
      sq_root_in = sq_root_ff;
      sq_cnt_in = sq_cnt_ff;
      rem_hi = '0;
      sq_trial = '0;
      if (cmd.sqrt_init) begin
         sq_rem_in = dxsq_ff + dysq_ff;
         sq_root_in = '0;
         sq_cnt_in = SqCntBits'(SqIter);
      end else if (cmd.sqrt_step) begin
         rem_hi = (RootBits+2)'(sq_rem_ff >> (2 * (sq_cnt_ff - 1'b1)));
         sq_trial = {sq_root_ff, 2'b01};
         sq_root_in = {sq_root_ff[RootBits-2:0], 1'b0};
         if (rem_hi >= sq_trial) begin
            sq_rem_in = sq_rem_ff - (D2Bits'(sq_trial) << (2 * (sq_cnt_ff - 1'b1)));
            sq_root_in = {sq_root_ff[RootBits-2:0], 1'b1};
         end
         sq_cnt_in = sq_cnt_ff - 1'b1;
      end
   end

   // Restoring divider: root / step.
   assign r_shift = {r_ff, q_ff[QBits-1]};
   always_comb begin
      q_in = q_ff; r_in = r_ff; q_cnt_in = q_cnt_ff;
      if (cmd.div_init) begin
         q_in = sq_root_ff;
         r_in = '0;
         q_cnt_in = QCntBits'(QBits);
      end else if (cmd.div_step) begin
         if (r_shift >= {2'b00, step_ff}) begin
            r_in = 17'(r_shift - {2'b00, step_ff});
            q_in = {q_ff[QBits-2:0], 1'b1};
         end else begin
            r_in = r_shift[16:0];
            q_in = {q_ff[QBits-2:0], 1'b0};
         end
         q_cnt_in = q_cnt_ff - 1'b1;
      end
   end

   always_comb begin
      n_in = n_ff; capped_in = capped_ff;
      if (cmd.count_fix) begin
         if (q_ff > QBits'(MaxPoints)) begin
            n_in = CntBits'(MaxPoints);
            capped_in = 1'b1;
         end else begin
            n_in = CntBits'(q_ff);
            capped_in = 1'b0;
         end
      end
   end

   assign f_val = n_ff - k_ff;

   // Per-point: product, then long division by n with remainder kept for rounding.
   assign rxs = {rx_ff, mx_ff[ProdBits-1]};
   assign rys = {ry_ff, my_ff[ProdBits-1]};
   always_comb begin
      k_in = k_ff; mx_in = mx_ff; my_in = my_ff;
      qx_in = qx_ff; qy_in = qy_ff; rx_in = rx_ff; ry_in = ry_ff; p_cnt_in = p_cnt_ff;
      if (cmd.pt_init) k_in = '0;
      if (cmd.pt_emit) k_in = k_ff + 1'b1;
      if (cmd.pt_div_init) begin
         mx_in = px_ff[ProdBits-1] ? ProdBits'(-px_ff) : ProdBits'(px_ff);
         my_in = py_ff[ProdBits-1] ? ProdBits'(-py_ff) : ProdBits'(py_ff);
         rx_in = '0; ry_in = '0;
         p_cnt_in = PCntBits'(ProdBits);
      end else if (cmd.pt_div_step) begin
         mx_in = {mx_ff[ProdBits-2:0], 1'b0};
         my_in = {my_ff[ProdBits-2:0], 1'b0};
         if (rxs >= {2'b00, n_ff}) begin
            rx_in = (CntBits+1)'(rxs - {2'b00, n_ff}); qx_in = {qx_ff[ProdBits-2:0], 1'b1};
         end else begin
            rx_in = rxs[CntBits:0]; qx_in = {qx_ff[ProdBits-2:0], 1'b0};
         end
         if (rys >= {2'b00, n_ff}) begin
            ry_in = (CntBits+1)'(rys - {2'b00, n_ff}); qy_in = {qy_ff[ProdBits-2:0], 1'b1};
         end else begin
            ry_in = rys[CntBits:0]; qy_in = {qy_ff[ProdBits-2:0], 1'b0};
         end
         p_cnt_in = p_cnt_ff - 1'b1;
      end
   end

   // Round half away from zero: bump when 2*rem >= n.
   assign qx_r = qx_ff + ProdBits'(({rx_ff, 1'b0} >= {2'b00, n_ff}) ? 1 : 0);
   assign qy_r = qy_ff + ProdBits'(({ry_ff, 1'b0} >= {2'b00, n_ff}) ? 1 : 0);
   assign sx = nx_ff ? -$signed({1'b0, qx_r}) : $signed({1'b0, qx_r});
   assign sy = ny_ff ? -$signed({1'b0, qy_r}) : $signed({1'b0, qy_r});
   assign ox = (n_ff == '0) ? (DBits+1)'(fx_ff + dx_ff) : (DBits+1)'(fx_ff) + (DBits+1)'(sx);
   assign oy = (n_ff == '0) ? (DBits+1)'(fy_ff + dy_ff) : (DBits+1)'(fy_ff) + (DBits+1)'(sy);

   always_ff @(posedge clock) begin
      fx_ff <= fx_in; fy_ff <= fy_in; dx_ff <= dx_in; dy_ff <= dy_in; step_ff <= step_in;
      dxsq_ff <= D2Bits'(dx_ff * dx_ff);
      dysq_ff <= D2Bits'(dy_ff * dy_ff);
      sq_rem_ff <= sq_rem_in; sq_root_ff <= sq_root_in; sq_cnt_ff <= sq_cnt_in;
      q_ff <= q_in; r_ff <= r_in; q_cnt_ff <= q_cnt_in;
      n_ff <= n_in; capped_ff <= capped_in; k_ff <= k_in;
      if (cmd.pt_mul) begin
         px_ff <= ProdBits'(dx_ff * $signed({1'b0, f_val}));
         py_ff <= ProdBits'(dy_ff * $signed({1'b0, f_val}));
      end
      if (cmd.pt_div_init) begin
         nx_ff <= px_ff[ProdBits-1];
         ny_ff <= py_ff[ProdBits-1];
      end
      mx_ff <= mx_in; my_ff <= my_in; qx_ff <= qx_in; qy_ff <= qy_in;
      rx_ff <= rx_in; ry_ff <= ry_in; p_cnt_ff <= p_cnt_in;
   end

   assign sts.sqrt_done = (sq_cnt_ff == '0);
   assign sts.div_done  = (q_cnt_ff == '0);
   assign sts.pdiv_done = (p_cnt_ff == '0);
   assign sts.run_last  = (n_ff == '0) || (k_ff + 1'b1 == n_ff);

   assign rsp_data.point_x = ox[15:0];
   assign rsp_data.point_y = oy[15:0];
   assign rsp_data.last    = sts.run_last;
   assign rsp_data.capped  = capped_ff;

endmodule

@@ sv/ltpg_control.sv @@
// Controller state machine sequencing the datapath for one request.
module ltpg_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  ltpg_pkg::sts_type sts,
   output ltpg_pkg::cmd_type cmd
);
   import ltpg_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_SQR    = 10'b0000000010,
      S_SQI    = 10'b0000000100,
      S_SQS    = 10'b0000001000,
      S_DIV    = 10'b0000010000,
      S_FIX    = 10'b0000100000,
      S_MUL    = 10'b0001000000,
      S_PDI    = 10'b0010000000,
      S_PDS    = 10'b0100000000,
      S_OUT    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
            if (req_valid) state_in = S_SQR;
         end
         S_SQR: state_in = S_SQI;
         S_SQI: begin
            cmd.sqrt_init = 1'b1;
            state_in = S_SQS;
         end
         S_SQS: begin
            if (sts.sqrt_done) begin
               cmd.div_init = 1'b1;
               state_in = S_DIV;
            end else cmd.sqrt_step = 1'b1;
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.count_fix = 1'b1;
               state_in = S_FIX;
            end else cmd.div_step = 1'b1;
         end
         S_FIX: begin
            cmd.pt_init = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.pt_mul = 1'b1;
            state_in = S_PDI;
         end
         S_PDI: begin
            cmd.pt_div_init = 1'b1;
            state_in = S_PDS;
         end
         S_PDS: begin
            if (sts.pdiv_done) state_in = S_OUT;
            else cmd.pt_div_step = 1'b1;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.pt_emit = 1'b1;
               state_in = sts.run_last ? S_IDLE : S_MUL;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

@@ sv/line_trajectory_point_generator.sv @@
// Top level of the line trajectory point generator.
// An accepted request first runs the squares, a 17-step square root and an 18-step
// count divide; each point then takes a multiply and a 24-step rounding divide.
// One request is served at a time, up to 64 points each. Synchronous active-high
// reset returns the controller to idle; the datapath holds no state that reset
// must clear.
module line_trajectory_point_generator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ltpg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ltpg_pkg::rsp_type rsp_data
);
   import ltpg_pkg::*;

   // Command and status bundles are the only link between the two halves.
   cmd_type cmd;
   sts_type sts;

   ltpg_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .sts(sts), .cmd(cmd)
   );

   ltpg_datapath u_datapath (
      .clock(clock), .req_data(req_data), .cmd(cmd), .sts(sts), .rsp_data(rsp_data)
   );

   // A request is only taken while no point is on offer.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall)) else $error("request taken during output");

   // A point held by a stall stays put.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled point changed");

   // Emitting and loading never coincide.
   a_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.pt_emit)) else $error("load and emit together");

endmodule

@@ verif/tb_line_trajectory_point_generator.sv @@
// Self-checking testbench for the line trajectory point generator.
`timescale 1ns / 100ps

module tb_line_trajectory_point_generator;
   import ltpg_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   line_trajectory_point_generator uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   // Points that the block is expected to emit, oldest first.
   rsp_type expected_points[$];

   int mismatches;
   int idle_cycles;
   int send_idle_pct;
   int stall_pct;
   int hold_off_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Integer square root of a non-negative value, bit by bit.
   function automatic longint unsigned root_of(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Quotient rounded to nearest, ties away from zero.
   function automatic longint rounded_quotient(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   // Work out every point that one request gives and queue them.
   task automatic predict_points(req_type r);
      longint fx, fy, tx, ty, dx, dy, n, f, cnt, step;
      logic cap;
      rsp_type p;
      fx = r.from_x;
      fy = r.from_y;
      tx = r.to_x;
      ty = r.to_y;
      step = (r.step_len == 0) ? 1 : r.step_len;
      dx = tx - fx;
      dy = ty - fy;
      n = longint'(root_of(longint'(dx * dx + dy * dy))) / step;
      cap = 1'b0;
      if (n > MaxPoints) begin
         n = MaxPoints;
         cap = 1'b1;
      end
      cnt = (n == 0) ? 1 : n;
      for (longint k = 0; k < cnt; k++) begin
         if (n == 0) begin
            p.point_x = tx[15:0];
            p.point_y = ty[15:0];
         end else begin
            f = n - k;
            p.point_x = 16'(fx + rounded_quotient(f * dx, n));
            p.point_y = 16'(fy + rounded_quotient(f * dy, n));
         end
         p.last = (k + 1 == cnt);
         p.capped = cap;
         expected_points.push_back(p);
      end
   endtask

   // Offer one request, idling beforehand at the current rate, and wait until it is taken.
   task automatic send_request(req_type r);
      while ($urandom_range(99, 0) < send_idle_pct) @(posedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_points(r);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_line(int fx, int fy, int tx, int ty, int step);
      req_type r;
      r.from_x = 16'(fx);
      r.from_y = 16'(fy);
      r.to_x = 16'(tx);
      r.to_y = 16'(ty);
      r.step_len = 16'(step);
      send_request(r);
   endtask

   // Random request: mostly short lines with modest steps so runs stay small,
   // with a share of fully random coordinates and steps.
   task automatic send_random_line();
      req_type r;
      int base_x, base_y;
      r.from_x = 16'($urandom);
      r.from_y = 16'($urandom);
      if ($urandom_range(3, 0) == 0) begin
         r.to_x = 16'($urandom);
         r.to_y = 16'($urandom);
         r.step_len = 16'($urandom);
      end else begin
         base_x = $signed(r.from_x);
         base_y = $signed(r.from_y);
         r.to_x = 16'(base_x + $signed($urandom_range(400, 0)) - 200);
         r.to_y = 16'(base_y + $signed($urandom_range(400, 0)) - 200);
         r.step_len = 16'($urandom_range(40, 0));
      end
      send_request(r);
   endtask

   task automatic wait_until_drained();
      while (expected_points.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic test_directed();
      send_line(0, 0, 0, 0, 1);                       // zero distance
      send_line(10, 10, 20, 20, 1000);                // step longer than line
      send_line(0, 0, 30, 40, 0);                     // zero step treated as one
      send_line(0, 0, 30, 40, 5);                     // exact ten points
      send_line(0, 0, -7, 3, 2);                      // rounding of negatives
      send_line(1, 1, 4, -6, 3);
      send_line(-32768, -32768, 32767, 32767, 1);     // capped, widest span
      send_line(32767, -32768, -32768, 32767, 65535); // largest step
      send_line(32767, 32767, -32768, -32768, 1024);
      send_line(-32768, 0, 32767, 0, 65535);
      send_line(0, 32767, 0, -32768, 1);
      send_line(5, 5, 5, 69, 1);                      // exactly the maximum
      send_line(5, 5, 5, 70, 1);                      // one past the maximum
      send_line(-1, -1, 1, 1, 1);
      send_line(100, -100, 103, -100, 2);             // odd distance, even step
      send_line(0, 0, 65535, 0, 16'hffff);
      wait_until_drained();
   endtask

   task automatic test_random_phase(int count, int idle_pct, int stall_rate);
      send_idle_pct = idle_pct;
      stall_pct = stall_rate;
      repeat (count) send_random_line();
      wait_until_drained();
   endtask

   // The receiver holds off for a long while as requests keep coming.
   task automatic test_back_pressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off_cycles = 3000;
      repeat (6) send_line(0, 0, 40, 0, 2);
      wait_until_drained();
   endtask

   // Receiver side: random stall, plus a long hold-off when asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < stall_pct);
      end
   end

   // Result checker: each accepted point against the oldest expected one.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected point %h", rsp_data);
         end else begin
            want = expected_points.pop_front();
            if (rsp_data.point_x !== want.point_x || rsp_data.point_y !== want.point_y ||
                rsp_data.last !== want.last || rsp_data.capped !== want.capped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"point mismatch: expected x=%0d y=%0d last=%b cap=%b, ",
                            "got x=%0d y=%0d last=%b cap=%b"},
                           want.point_x, want.point_y, want.last, want.capped,
                           rsp_data.point_x, rsp_data.point_y, rsp_data.last,
                           rsp_data.capped);
            end
         end
      end
   end

   // Watchdog: ends the run when nothing has been accepted for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 40000) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      mismatches = 0;
      idle_cycles = 0;
      hold_off_cycles = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(90, 0, 0);
      test_random_phase(80, 83, 0);
      test_random_phase(80, 0, 83);
      test_random_phase(80, 24, 24);
      test_back_pressure();
      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
